FILE: hdl/trc_pkg.sv
// Shared types and constants of the triangle rectangle clipper.
// No dependencies; used by the interfaces, the divider and the top level.
`timescale 1ns / 1ps
package trc_pkg;

  localparam int XY_W   = 20;  // x, y: signed, 4 fraction bits
  localparam int AT_W   = 17;  // z, rhw, u, v: unsigned, 16 fraction bits
  localparam int COL_W  = 32;  // packed ARGB
  localparam int VN_W   = 3;   // vertex number in the emitted polygon
  localparam int CFG_AW = 4;   // byte address of four 32-bit registers
  localparam int CFG_DW = 32;

  localparam int POLY_SLOTS_DEF = 8;
  localparam int MAX_EMIT       = 7;

  // Crossing point arithmetic
  localparam int NUM_W  = 20;             // clamped numerator and denominator
  localparam int VAL_W  = 22;             // attribute value, signed
  localparam int PROD_W = NUM_W + 1 + VAL_W;
  localparam int DVS_W  = 22;             // divisor width (2*den for color)
  localparam int Q_W    = 22;             // quotient bits produced
  localparam int DVD_W  = DVS_W + Q_W;    // dividend width

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_TOP    = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [AT_W-1:0]        z;
    logic [AT_W-1:0]        w;
    logic [AT_W-1:0]        u;
    logic [AT_W-1:0]        v;
    logic [COL_W-1:0]       col;
  } vtx_t;

endpackage

FILE: hdl/trc_ifs.sv
// Valid/ready channels of the clipper: vertex input and clipped vertex output.
// Depends on trc_pkg for field widths.
`timescale 1ns / 1ps
interface trc_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [trc_pkg::XY_W-1:0] in_x;
  logic signed [trc_pkg::XY_W-1:0] in_y;
  logic [trc_pkg::AT_W-1:0]        in_z;
  logic [trc_pkg::AT_W-1:0]        in_rhw;
  logic [trc_pkg::COL_W-1:0]       in_color;
  logic [trc_pkg::AT_W-1:0]        in_u;
  logic [trc_pkg::AT_W-1:0]        in_v;

  modport source (output valid, in_x, in_y, in_z, in_rhw, in_color, in_u, in_v,
                  input ready);
  modport sink   (input valid, in_x, in_y, in_z, in_rhw, in_color, in_u, in_v,
                  output ready);
endinterface

interface trc_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [trc_pkg::XY_W-1:0] out_x;
  logic signed [trc_pkg::XY_W-1:0] out_y;
  logic [trc_pkg::AT_W-1:0]        out_z;
  logic [trc_pkg::AT_W-1:0]        out_rhw;
  logic [trc_pkg::COL_W-1:0]       out_color;
  logic [trc_pkg::AT_W-1:0]        out_u;
  logic [trc_pkg::AT_W-1:0]        out_v;
  logic [trc_pkg::VN_W-1:0]        vertex_number;
  logic                            last_vertex;

  modport source (output valid, out_x, out_y, out_z, out_rhw, out_color, out_u, out_v,
                  vertex_number, last_vertex, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_rhw, out_color, out_u, out_v,
                  vertex_number, last_vertex, output ready);
endinterface

FILE: hdl/trc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, floor rounding.
// Depends on trc_pkg for widths.
`timescale 1ns / 1ps
module trc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [trc_pkg::DVD_W-1:0] dividend,
  input  logic [trc_pkg::DVS_W-1:0]        divisor,
  output logic                             done,
  output logic signed [trc_pkg::Q_W:0]     quo
);
  import trc_pkg::*;

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DVS_W-1:0] rem_r;
  logic [Q_W-1:0]   sh_r;
  logic [DVS_W-1:0] div_r;
  logic             neg_r;
  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;

  logic [DVD_W-1:0] mag;
  logic [DVS_W:0]   rem2;
  logic             ge;
  logic [DVS_W:0]   rem_sub;
  logic [Q_W:0]     qmag;

  assign mag     = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
  assign rem2    = {rem_r, sh_r[Q_W-1]};
  assign ge      = rem2 >= {1'b0, div_r};
  assign rem_sub = rem2 - {1'b0, div_r};
  // magnitude quotient; a negative dividend with a remainder rounds one further down
  assign qmag    = {1'b0, sh_r} + (Q_W+1)'(rem_r != '0 && neg_r);
  assign quo     = neg_r ? $signed(-qmag) : $signed(qmag);
  assign done    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        neg_r  <= dividend[DVD_W-1];
        rem_r  <= mag[DVD_W-1:Q_W];  // below divisor since the quotient fits Q_W bits
        sh_r   <= mag[Q_W-1:0];
        div_r  <= divisor;
        cnt_r  <= CNT_W'(Q_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sub[DVS_W-1:0] : rem2[DVS_W-1:0];
        sh_r  <= {sh_r[Q_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end
endmodule

FILE: hdl/triangle_rect_clipper_unit.sv
// Top level of the triangle rectangle clipper: sequencer, polygon memory, APB registers.
// Depends on trc_pkg, trc_ifs (channels) and trc_div (shared divider).
`timescale 1ns / 1ps
// Vertices come in one beat each; every third closes a triangle. The first two are
// written to the polygon memory as they are taken. The third starts up to four clip
// passes (left, top, right, bottom) over a two-bank polygon memory with one read and
// one write port, and the input stays not ready until the last output beat of the
// polygon is taken, or until the passes end if nothing is emitted. Each polygon edge
// reads both end points, decides, and writes its output vertices; each crossing point
// is interpolated by the single 22-step divider that is shared by the nine values
// (other coordinate, z, rhw, u, v, four color bytes), one after another. Each output
// beat is read and registered only after the previous one is taken. Polygons of fewer
// than three vertices emit nothing; at most seven vertices go out, the last one flagged.
module triangle_rect_clipper_unit #(
  parameter int POLY_SLOTS = trc_pkg::POLY_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  trc_in_if.sink                       in_ch,
  trc_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [trc_pkg::CFG_AW-1:0]   paddr,
  input  logic [trc_pkg::CFG_DW-1:0]   pwdata,
  output logic [trc_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);
  import trc_pkg::*;

  localparam int IDX_W = $clog2(POLY_SLOTS);
  localparam int CNT_W = $clog2(POLY_SLOTS + 1);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_PASS  = 5'd1;
  localparam logic [4:0] ST_RDP   = 5'd2;
  localparam logic [4:0] ST_RDQ   = 5'd3;
  localparam logic [4:0] ST_CAPQ  = 5'd4;
  localparam logic [4:0] ST_DEC   = 5'd5;
  localparam logic [4:0] ST_XSET  = 5'd6;
  localparam logic [4:0] ST_XMUL  = 5'd7;
  localparam logic [4:0] ST_XDIVS = 5'd8;
  localparam logic [4:0] ST_XDIVW = 5'd9;
  localparam logic [4:0] ST_WRC   = 5'd10;
  localparam logic [4:0] ST_WRQ   = 5'd11;
  localparam logic [4:0] ST_NEXT  = 5'd12;
  localparam logic [4:0] ST_ECHK  = 5'd13;
  localparam logic [4:0] ST_ERD   = 5'd14;
  localparam logic [4:0] ST_ECAP  = 5'd15;
  localparam logic [4:0] ST_EOUT  = 5'd16;

  localparam logic [3:0] ATTR_OTHER = 4'd0;
  localparam logic [3:0] ATTR_Z     = 4'd1;
  localparam logic [3:0] ATTR_W     = 4'd2;
  localparam logic [3:0] ATTR_U     = 4'd3;
  localparam logic [3:0] ATTR_V     = 4'd4;
  localparam logic [3:0] ATTR_COL0  = 4'd5;
  localparam logic [3:0] ATTR_COL1  = 4'd6;
  localparam logic [3:0] ATTR_COL2  = 4'd7;
  localparam logic [3:0] ATTR_COL3  = 4'd8;

  localparam logic [2:0] SIDE_DONE = 3'd4;

  // ---------------- configuration registers ----------------
  logic signed [XY_W-1:0] left_r, top_r, right_r, bottom_r;
  logic [XY_W-1:0]        rd_reg;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= {1'b0, {(XY_W-1){1'b1}}};
      bottom_r <= {1'b0, {(XY_W-1){1'b1}}};
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_LEFT:   left_r   <= pwdata[XY_W-1:0];
        REG_TOP:    top_r    <= pwdata[XY_W-1:0];
        REG_RIGHT:  right_r  <= pwdata[XY_W-1:0];
        REG_BOTTOM: bottom_r <= pwdata[XY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LEFT:   rd_reg = left_r;
      REG_TOP:    rd_reg = top_r;
      REG_RIGHT:  rd_reg = right_r;
      REG_BOTTOM: rd_reg = bottom_r;
      default:    rd_reg = '0;
    endcase
  end
  assign prdata = {{(CFG_DW-XY_W){1'b0}}, rd_reg};

  // ---------------- state ----------------
  logic [4:0]       state_r;
  logic [1:0]       phase_r;
  logic [2:0]       side_r;
  logic             bank_r;
  logic [CNT_W-1:0] n_r, m_r, i_r;
  logic [3:0]       k_r;
  logic [VN_W-1:0]  j_r, emit_r;
  logic             inq_r;
  logic [NUM_W-1:0] num_r, den_r;
  logic signed [PROD_W-1:0] prod_r;
  vtx_t             p_r, q_r, c_r, rd_r;

  logic             ov_r, olast_r;
  vtx_t             ov_vtx_r;
  logic [VN_W-1:0]  ovn_r;

  vtx_t             mem [2][POLY_SLOTS];

  // ---------------- memory ports ----------------
  vtx_t             in_vtx, wd;
  logic             we, wb;
  logic [IDX_W-1:0] wi, ri;
  logic [CNT_W-1:0] ip1;
  logic             in_acc;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign ip1    = i_r + CNT_W'(1);

  always_comb begin
    in_vtx.x   = in_ch.in_x;
    in_vtx.y   = in_ch.in_y;
    in_vtx.z   = in_ch.in_z;
    in_vtx.w   = in_ch.in_rhw;
    in_vtx.col = in_ch.in_color;
    in_vtx.u   = in_ch.in_u;
    in_vtx.v   = in_ch.in_v;
  end

  always_comb begin
    we = 1'b0;
    wb = 1'b0;
    wi = '0;
    wd = in_vtx;
    case (state_r)
      ST_IDLE: begin
        we = in_acc;
        wi = IDX_W'(phase_r);
      end
      ST_WRC: begin
        we = m_r < CNT_W'(POLY_SLOTS);
        wb = ~bank_r;
        wi = m_r[IDX_W-1:0];
        wd = c_r;
      end
      ST_WRQ: begin
        we = m_r < CNT_W'(POLY_SLOTS);
        wb = ~bank_r;
        wi = m_r[IDX_W-1:0];
        wd = q_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_RDQ:  ri = (ip1 == n_r) ? '0 : ip1[IDX_W-1:0];
      ST_ERD:  ri = IDX_W'(j_r);
      default: ri = i_r[IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wb][wi] <= wd;
    rd_r <= mem[bank_r][ri];
  end

  // ---------------- inside tests and crossing setup ----------------
  logic                   vertical;
  logic signed [XY_W-1:0] edge_val, pc, qc;
  logic                   in_p, in_q;
  logic signed [XY_W:0]   d, num0;
  logic signed [XY_W+1:0] numa, dena;
  logic [NUM_W-1:0]       num_cl;
  vtx_t                   c_init;

  function automatic logic vtx_in(vtx_t v, logic [1:0] s, logic signed [XY_W-1:0] e);
    case (s)
      REG_LEFT:   vtx_in = v.x >= e;
      REG_TOP:    vtx_in = v.y >= e;
      REG_RIGHT:  vtx_in = v.x <= e;
      default:    vtx_in = v.y <= e;
    endcase
  endfunction

  assign vertical = ~side_r[0];

  always_comb begin
    case (side_r[1:0])
      REG_LEFT:   edge_val = left_r;
      REG_TOP:    edge_val = top_r;
      REG_RIGHT:  edge_val = right_r;
      default:    edge_val = bottom_r;
    endcase
  end

  assign in_p = vtx_in(p_r, side_r[1:0], edge_val);
  assign in_q = vtx_in(q_r, side_r[1:0], edge_val);
  assign pc   = vertical ? p_r.x : p_r.y;
  assign qc   = vertical ? q_r.x : q_r.y;
  assign d    = $signed({qc[XY_W-1], qc}) - $signed({pc[XY_W-1], pc});
  assign num0 = $signed({edge_val[XY_W-1], edge_val}) - $signed({pc[XY_W-1], pc});

  always_comb begin
    // orient so the denominator is positive, then clamp t to [0, 1]
    if (d < 0) begin
      numa = -$signed({num0[XY_W], num0});
      dena = -$signed({d[XY_W], d});
    end else begin
      numa = $signed({num0[XY_W], num0});
      dena = $signed({d[XY_W], d});
    end
    if (numa < 0)         num_cl = '0;
    else if (numa > dena) num_cl = dena[NUM_W-1:0];
    else                  num_cl = numa[NUM_W-1:0];
  end

  // crossing point starts as P with the cut coordinate on the edge
  always_comb begin
    c_init = p_r;
    if (vertical) c_init.x = edge_val;
    else          c_init.y = edge_val;
  end

  // ---------------- interpolation through the shared divider ----------------
  function automatic logic signed [VAL_W-1:0] attr_val(vtx_t v, logic [3:0] k, logic vert);
    case (k)
      ATTR_OTHER: attr_val = vert ? VAL_W'(v.y) : VAL_W'(v.x);
      ATTR_Z:     attr_val = $signed({{(VAL_W-AT_W){1'b0}}, v.z});
      ATTR_W:     attr_val = $signed({{(VAL_W-AT_W){1'b0}}, v.w});
      ATTR_U:     attr_val = $signed({{(VAL_W-AT_W){1'b0}}, v.u});
      ATTR_V:     attr_val = $signed({{(VAL_W-AT_W){1'b0}}, v.v});
      ATTR_COL0:  attr_val = $signed({{(VAL_W-8){1'b0}}, v.col[7:0]});
      ATTR_COL1:  attr_val = $signed({{(VAL_W-8){1'b0}}, v.col[15:8]});
      ATTR_COL2:  attr_val = $signed({{(VAL_W-8){1'b0}}, v.col[23:16]});
      ATTR_COL3:  attr_val = $signed({{(VAL_W-8){1'b0}}, v.col[31:24]});
      default:    attr_val = '0;
    endcase
  endfunction

  logic signed [VAL_W-1:0]  pv, qv, diff;
  logic                     is_col;
  logic signed [DVD_W-1:0]  prod_ext, dvd;
  logic [DVS_W-1:0]         dvs;
  logic                     div_done;
  logic signed [Q_W:0]      quo;
  logic signed [VAL_W+1:0]  res;

  assign pv       = attr_val(p_r, k_r, vertical);
  assign qv       = attr_val(q_r, k_r, vertical);
  assign diff     = qv - pv;
  assign is_col   = k_r >= ATTR_COL0;
  assign prod_ext = $signed({prod_r[PROD_W-1], prod_r});
  // color bytes round half up: floor((2*num*(b-a) + den) / (2*den))
  assign dvd      = is_col ? (prod_ext <<< 1) + $signed({{(DVD_W-NUM_W){1'b0}}, den_r})
                           : prod_ext;
  assign dvs      = is_col ? {1'b0, den_r, 1'b0} : {2'b00, den_r};
  assign res      = $signed({pv[VAL_W-1], pv[VAL_W-1], pv}) + $signed({quo[Q_W], quo});

  trc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_XDIVS),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quo      (quo)
  );

  // ---------------- sequencer ----------------
  assign in_ch.ready = state_r == ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 2'd0;
      ov_r    <= 1'b0;
      side_r  <= '0;
      bank_r  <= 1'b0;
      n_r     <= '0;
      m_r     <= '0;
      i_r     <= '0;
      k_r     <= '0;
      j_r     <= '0;
      emit_r  <= '0;
      inq_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (phase_r == 2'd2) begin
              phase_r <= 2'd0;
              n_r     <= CNT_W'(3);
              side_r  <= '0;
              bank_r  <= 1'b0;
              state_r <= ST_PASS;
            end else begin
              phase_r <= phase_r + 2'd1;
            end
          end
        end
        ST_PASS: begin
          if (side_r == SIDE_DONE || n_r == '0) begin
            state_r <= ST_ECHK;
          end else begin
            i_r     <= '0;
            m_r     <= '0;
            state_r <= ST_RDP;
          end
        end
        ST_RDP:  state_r <= ST_RDQ;
        ST_RDQ: begin
          p_r     <= rd_r;
          state_r <= ST_CAPQ;
        end
        ST_CAPQ: begin
          q_r     <= rd_r;
          state_r <= ST_DEC;
        end
        ST_DEC: begin
          inq_r <= in_q;
          if (in_p && in_q)      state_r <= ST_WRQ;
          else if (in_p || in_q) state_r <= ST_XSET;
          else                   state_r <= ST_NEXT;
        end
        ST_XSET: begin
          if (d == 0) begin
            c_r     <= p_r;
            state_r <= ST_WRC;  // degenerate edge: crossing point is P
          end else begin
            c_r     <= c_init;
            num_r   <= num_cl;
            den_r   <= dena[NUM_W-1:0];
            k_r     <= ATTR_OTHER;
            state_r <= ST_XMUL;
          end
        end
        ST_XMUL: begin
          prod_r  <= $signed({1'b0, num_r}) * diff;
          state_r <= ST_XDIVS;
        end
        ST_XDIVS: state_r <= ST_XDIVW;
        ST_XDIVW: begin
          if (div_done) begin
            case (k_r)
              ATTR_OTHER: begin
                if (vertical) c_r.y <= res[XY_W-1:0];
                else          c_r.x <= res[XY_W-1:0];
              end
              ATTR_Z:    c_r.z          <= res[AT_W-1:0];
              ATTR_W:    c_r.w          <= res[AT_W-1:0];
              ATTR_U:    c_r.u          <= res[AT_W-1:0];
              ATTR_V:    c_r.v          <= res[AT_W-1:0];
              ATTR_COL0: c_r.col[7:0]   <= res[7:0];
              ATTR_COL1: c_r.col[15:8]  <= res[7:0];
              ATTR_COL2: c_r.col[23:16] <= res[7:0];
              default:   c_r.col[31:24] <= res[7:0];
            endcase
            if (k_r == ATTR_COL3) begin
              state_r <= ST_WRC;
            end else begin
              k_r     <= k_r + 4'd1;
              state_r <= ST_XMUL;
            end
          end
        end
        ST_WRC: begin
          if (m_r < CNT_W'(POLY_SLOTS)) m_r <= m_r + CNT_W'(1);
          state_r <= inq_r ? ST_WRQ : ST_NEXT;
        end
        ST_WRQ: begin
          if (m_r < CNT_W'(POLY_SLOTS)) m_r <= m_r + CNT_W'(1);
          state_r <= ST_NEXT;
        end
        ST_NEXT: begin
          if (ip1 == n_r) begin
            n_r     <= m_r;
            bank_r  <= ~bank_r;
            side_r  <= side_r + 3'd1;
            state_r <= ST_PASS;
          end else begin
            i_r     <= ip1;
            state_r <= ST_RDP;
          end
        end
        ST_ECHK: begin
          if (n_r < CNT_W'(3)) begin
            state_r <= ST_IDLE;
          end else begin
            emit_r  <= (n_r > CNT_W'(MAX_EMIT)) ? VN_W'(MAX_EMIT) : VN_W'(n_r);
            j_r     <= '0;
            state_r <= ST_ERD;
          end
        end
        ST_ERD: state_r <= ST_ECAP;
        ST_ECAP: begin
          ov_vtx_r <= rd_r;
          ovn_r    <= j_r;
          olast_r  <= (j_r + VN_W'(1)) == emit_r;
          ov_r     <= 1'b1;
          state_r  <= ST_EOUT;
        end
        ST_EOUT: begin
          if (out_ch.ready) begin
            ov_r <= 1'b0;
            if (olast_r) begin
              state_r <= ST_IDLE;
            end else begin
              j_r     <= j_r + VN_W'(1);
              state_r <= ST_ERD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.out_x         = ov_vtx_r.x;
  assign out_ch.out_y         = ov_vtx_r.y;
  assign out_ch.out_z         = ov_vtx_r.z;
  assign out_ch.out_rhw       = ov_vtx_r.w;
  assign out_ch.out_color     = ov_vtx_r.col;
  assign out_ch.out_u         = ov_vtx_r.u;
  assign out_ch.out_v         = ov_vtx_r.v;
  assign out_ch.vertex_number = ovn_r;
  assign out_ch.last_vertex   = olast_r;

endmodule

FILE: bench/triangle_rect_clipper_unit_tb.sv
// Self-checking bench for the triangle rectangle clipper: random and directed vertex
// streams against a clip-and-interpolate predictor, APB register writes between phases.
// Depends on trc_pkg, trc_ifs and the clipper top level.
`timescale 1ns / 1ps

typedef struct {
  longint x, y, z, w, u, v;
  longint col;
} clip_vtx_t;

typedef struct {
  longint x, y, z, w, col, u, v, num, last;
} clip_beat_t;

class clip_scoreboard;
  longint left, top, right, bottom;
  clip_vtx_t held[2];
  int phase;
  clip_beat_t pending[$];
  int errors;

  function new();
    left = 0; top = 0; right = 524287; bottom = 524287;
    phase = 0; errors = 0;
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic bit inside_edge(clip_vtx_t p, int side);
    case (side)
      0: return p.x >= left;
      1: return p.y >= top;
      2: return p.x <= right;
      default: return p.y <= bottom;
    endcase
  endfunction

  function automatic clip_vtx_t crossing(clip_vtx_t p, clip_vtx_t q, int side);
    clip_vtx_t r;
    bit vert;
    longint e, num, den, a, b, c;
    r = p;
    vert = (side == 0 || side == 2);
    e = side == 0 ? left : side == 1 ? top : side == 2 ? right : bottom;
    den = vert ? q.x - p.x : q.y - p.y;
    if (den == 0) return p;
    num = e - (vert ? p.x : p.y);
    if (den < 0) begin
      num = -num; den = -den;
    end
    if (num < 0) num = 0;
    if (num > den) num = den;
    if (vert) begin
      r.x = e; r.y = p.y + fdiv(num * (q.y - p.y), den);
    end else begin
      r.y = e; r.x = p.x + fdiv(num * (q.x - p.x), den);
    end
    r.z = p.z + fdiv(num * (q.z - p.z), den);
    r.w = p.w + fdiv(num * (q.w - p.w), den);
    r.u = p.u + fdiv(num * (q.u - p.u), den);
    r.v = p.v + fdiv(num * (q.v - p.v), den);
    r.col = 0;
    for (int sh = 0; sh < 32; sh += 8) begin
      a = (p.col >> sh) & 255;
      b = (q.col >> sh) & 255;
      c = a + fdiv(2 * num * (b - a) + den, 2 * den);
      r.col |= (c & 255) << sh;
    end
    return r;
  endfunction

  // Returns the number of beats the vertex adds to the expected queue
  function automatic int note_vertex(clip_vtx_t cur);
    clip_vtx_t poly[$], nxt[$], p, q;
    int n, emit;
    clip_beat_t bt;
    if (phase < 2) begin
      held[phase] = cur;
      phase++;
      return 0;
    end
    phase = 0;
    poly = '{held[0], held[1], cur};
    for (int side = 0; side < 4 && poly.size() > 0; side++) begin
      nxt = {};
      n = poly.size();
      for (int i = 0; i < n; i++) begin
        p = poly[i]; q = poly[(i + 1) % n];
        if (inside_edge(p, side) && inside_edge(q, side)) begin
          if (nxt.size() < 8) nxt = {nxt, q};
        end else if (inside_edge(p, side)) begin
          if (nxt.size() < 8) nxt = {nxt, crossing(p, q, side)};
        end else if (inside_edge(q, side)) begin
          if (nxt.size() < 8) nxt = {nxt, crossing(p, q, side)};
          if (nxt.size() < 8) nxt = {nxt, q};
        end
      end
      poly = nxt;
    end
    if (poly.size() < 3) return 0;
    emit = poly.size() > 7 ? 7 : poly.size();
    for (int i = 0; i < emit; i++) begin
      bt.x = poly[i].x & 20'hFFFFF; bt.y = poly[i].y & 20'hFFFFF;
      bt.z = poly[i].z & 17'h1FFFF; bt.w = poly[i].w & 17'h1FFFF;
      bt.col = poly[i].col & 32'hFFFFFFFF;
      bt.u = poly[i].u & 17'h1FFFF; bt.v = poly[i].v & 17'h1FFFF;
      bt.num = i; bt.last = (i == emit - 1);
      pending = {pending, bt};
    end
    return emit;
  endfunction

  function automatic void cmp(string name, longint e, longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0h actual %0h", name, e, a);
      errors++;
    end
  endfunction

  function automatic void check_beat(clip_beat_t got);
    clip_beat_t e;
    if (pending.size() == 0) begin
      $error("output beat with nothing expected");
      errors++;
      return;
    end
    e = pending.pop_front();
    cmp("out_x", e.x, got.x); cmp("out_y", e.y, got.y);
    cmp("out_z", e.z, got.z); cmp("out_rhw", e.w, got.w);
    cmp("out_color", e.col, got.col);
    cmp("out_u", e.u, got.u); cmp("out_v", e.v, got.v);
    cmp("vertex_number", e.num, got.num); cmp("last_vertex", e.last, got.last);
  endfunction
endclass

module triangle_rect_clipper_unit_tb;
  import trc_pkg::*;

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;
  logic pready;
  longint cycles;

  trc_in_if in_ch ();
  trc_out_if out_ch ();
  clip_scoreboard sb;

  triangle_rect_clipper_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Result side: random stalls, compare at accepting edge
  initial begin
    clip_beat_t got;
    int wait_n;
    out_ch.ready = 0;
    @(posedge clk);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (wait_n != 0) begin
        out_ch.ready <= 0;
        repeat (wait_n) @(posedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      got.x = out_ch.out_x & 20'hFFFFF; got.y = out_ch.out_y & 20'hFFFFF;
      got.z = out_ch.out_z; got.w = out_ch.out_rhw; got.col = out_ch.out_color;
      got.u = out_ch.out_u; got.v = out_ch.out_v;
      got.num = out_ch.vertex_number; got.last = out_ch.last_vertex;
      sb.check_beat(got);
    end
  end

  task automatic cfg_write(logic [1:0] idx, longint val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= CFG_AW'(idx) << 2; pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
    case (idx)
      REG_LEFT:   sb.left = val;
      REG_TOP:    sb.top = val;
      REG_RIGHT:  sb.right = val;
      default:    sb.bottom = val;
    endcase
  endtask

  task automatic set_rect(longint l, longint t, longint r, longint b);
    cfg_write(REG_LEFT, l); cfg_write(REG_TOP, t);
    cfg_write(REG_RIGHT, r); cfg_write(REG_BOTTOM, b);
  endtask

  // stop sending and wait until the block is idle with nothing left to check
  task automatic hold_off();
    in_ch.valid <= 0;
    do @(posedge clk); while (sb.pending.size() != 0 || !in_ch.ready);
  endtask

  task automatic drain();
    hold_off();
    repeat (400) @(posedge clk);
  endtask

  task automatic send_vertex(clip_vtx_t vx, bit gaps);
    int wait_n;
    wait_n = gaps ? $urandom_range(0, 7) : 0;
    if (wait_n != 0) begin
      in_ch.valid <= 0;
      repeat (wait_n) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.in_x <= vx.x[19:0]; in_ch.in_y <= vx.y[19:0];
    in_ch.in_z <= vx.z[16:0]; in_ch.in_rhw <= vx.w[16:0];
    in_ch.in_color <= vx.col[31:0];
    in_ch.in_u <= vx.u[16:0]; in_ch.in_v <= vx.v[16:0];
    do @(posedge clk); while (!in_ch.ready);
    void'(sb.note_vertex(vx));
  endtask

  function automatic clip_vtx_t mk(longint x, longint y, bit full_attr);
    clip_vtx_t r;
    r.x = x; r.y = y;
    r.z = full_attr ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
    r.w = full_attr ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
    r.u = full_attr ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
    r.v = full_attr ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
    r.col = $urandom;
    return r;
  endfunction

  function automatic longint rnd_xy(longint lo, longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  task automatic random_triangles(int n_tri, longint span_lo, longint span_hi);
    bit gaps;
    for (int i = 0; i < n_tri; i++) begin
      gaps = (i % 16) < 11;
      for (int k = 0; k < 3; k++)
        send_vertex(mk(rnd_xy(span_lo, span_hi), rnd_xy(span_lo, span_hi),
                       $urandom_range(0, 3) == 0), gaps);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_ch.valid = 0; in_ch.in_x = '0; in_ch.in_y = '0; in_ch.in_z = '0;
    in_ch.in_rhw = '0; in_ch.in_color = '0; in_ch.in_u = '0; in_ch.in_v = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset rect, fully inside, and a vertical edge outside the left side
    send_vertex(mk(16, 16, 1), 0); send_vertex(mk(800, 32, 1), 0);
    send_vertex(mk(400, 900, 1), 0);
    send_vertex(mk(-100, 50, 0), 0); send_vertex(mk(-100, 500, 0), 0);
    send_vertex(mk(300, 200, 0), 0);
    drain();
    set_rect(100, 100, 400, 400);
    // Triangle that encloses the rectangle, all corners cut
    send_vertex(mk(250, -200, 1), 0); send_vertex(mk(700, 500, 1), 0);
    send_vertex(mk(-200, 500, 1), 0);
    // fully outside, and zero-area on an edge
    send_vertex(mk(-500, -500, 0), 0); send_vertex(mk(-400, -500, 0), 0);
    send_vertex(mk(-450, -300, 0), 0);
    send_vertex(mk(100, 100, 0), 0); send_vertex(mk(100, 400, 0), 0);
    send_vertex(mk(100, 250, 0), 0);
    drain();
    // extreme coordinates with full-range rectangle
    set_rect(-524288, -524288, 524287, 524287);
    send_vertex(mk(-524288, -524288, 1), 0); send_vertex(mk(524287, -524288, 1), 0);
    send_vertex(mk(0, 524287, 1), 0);
    drain();
    // inverted rectangle: nothing out
    set_rect(300, 300, 200, 200);
    send_vertex(mk(250, 250, 0), 0); send_vertex(mk(260, 250, 0), 0);
    send_vertex(mk(250, 260, 0), 0);
    drain();

    // Random phases over several rectangles
    set_rect(-1000, -1000, 1000, 1000);
    random_triangles(30, -2000, 2000);
    hold_off();   // sender holds off until empty
    random_triangles(10, -2000, 2000);
    drain();
    set_rect(-524288, 0, 0, 524287);
    random_triangles(20, -524288, 524287);
    drain();
    set_rect($urandom_range(0, 50), $urandom_range(0, 50),
             $urandom_range(200, 300), $urandom_range(200, 300));
    random_triangles(30, -200, 500);
    drain();
    set_rect(0, 0, 524287, 524287);
    random_triangles(10, -524288, 524287);
    drain();

    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

FILE: files.f
hdl/trc_pkg.sv
hdl/trc_ifs.sv
hdl/trc_div.sv
hdl/triangle_rect_clipper_unit.sv
bench/triangle_rect_clipper_unit_tb.sv
